/* sv/timer_queue_manager_assert.svh */
// assertion macros for the timer queue manager
`ifndef TIMER_QUEUE_MANAGER_ASSERT_SVH
`define TIMER_QUEUE_MANAGER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TQM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("timer queue check failed");

// next-cycle implication, checked outside reset
`define TQM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("timer queue check failed");

`endif

/* sv/tqm_pkg.sv */
package tqm_pkg;

    // default table depth
    localparam int MAX_TIMERS_DEF = 16;

    // stream widths
    localparam int S_TDATA_W = 136;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 2;

    // request codes
    localparam logic [2:0] REQ_ADD    = 3'd0;
    localparam logic [2:0] REQ_CANCEL = 3'd1;
    localparam logic [2:0] REQ_CHANGE = 3'd2;
    localparam logic [2:0] REQ_QUERY  = 3'd3;
    localparam logic [2:0] REQ_TICK   = 3'd4;

    // status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;
    localparam logic [1:0] STS_NONE_DUE  = 2'd3;

    // shared adder operation
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    // one timer slot as kept in the slot memory
    typedef struct packed {
        logic [31:0] id;
        logic [63:0] due;
        logic [31:0] interval;
        logic        periodic;
    } t_slot;

    // flags from the shared adder
    typedef struct packed {
        logic [63:0] sum;
        logic        neg;
        logic        zero;
    } t_alu_res;

endpackage

/* sv/tqm_store.sv */
module tqm_store
    import tqm_pkg::*;
#(
    parameter int DEPTH = MAX_TIMERS_DEF,
    parameter int IDX_W = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_slot            i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output t_slot            o_rdata
);

    t_slot r_mem [DEPTH];
    t_slot r_rdata;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/tqm_alu.sv */
module tqm_alu
    import tqm_pkg::*;
(
    input  t_alu_op     i_op,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output t_alu_res    o_res
);

    logic [63:0] sum;

    // 64-bit add or subtract, wraps modulo 2^64
    always_comb begin
        case (i_op)
            ALU_ADD: sum = i_a + i_b;
            ALU_SUB: sum = i_a - i_b;
            default: sum = i_a + i_b;
        endcase
    end

    // sign and zero of the result, read as signed
    assign o_res.sum  = sum;
    assign o_res.neg  = sum[63];
    assign o_res.zero = (sum == 64'd0);

endmodule

/* sv/timer_queue_manager.sv */
// timer queue manager: table of MAX_TIMERS software timers
// input channel (s_axis): one request per transaction, kind in tuser
// (add, cancel, change, query, tick), id, interval, mode and current
// time in tdata. output channel (m_axis): one response per request,
// status in tuser, result id, time left and fired flag in tdata.
// each request walks every slot of the slot memory through its single
// registered read port, one slot a cycle, with one 64-bit adder shared
// by the due-time compare, the time-left subtract and the re-arm add.
// a request passes through the scan, tail and fin states, then re-arm
// when a tick re-arms a periodic timer, then push, which sets output
// valid once the output register is free; the next request is taken
// only after that push. tready is high only between requests.
// reset clears the valid bits, the id counter and both handshakes; the
// slot memory itself is not cleared, entries count only once valid.
// a stalled receiver holds the response in the output register; the
// next request is still taken and worked on, and its response waits
// until the output register is free.
module timer_queue_manager
    import tqm_pkg::*;
#(
    parameter int MAX_TIMERS = MAX_TIMERS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // req_id[31:0], interval[63:32], periodic[64], now_time[128:65]
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // req_type[2:0]
    input  logic [S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // result_id[31:0], remaining[63:32], fired[64]
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // status[1:0]
    output logic [M_TUSER_W-1:0] o_m_axis_tuser
);

    `include "timer_queue_manager_assert.svh"

    localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TIMERS - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_TAIL  = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_REARM = 3'd4;
    localparam logic [2:0] S_PUSH  = 3'd5;

    // control registers
    logic [2:0]            r_state, n_state;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic                  r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]      r_rd_idx, n_rd_idx;
    logic                  r_found, n_found;
    logic [MAX_TIMERS-1:0] r_valid, n_valid;
    logic [31:0]           r_next_id, n_next_id;
    logic                  r_out_valid, n_out_valid;

    // payload registers
    logic [2:0]       r_req_type, n_req_type;
    logic [31:0]      r_tid, n_tid;
    logic [31:0]      r_ivl, n_ivl;
    logic             r_per, n_per;
    logic [63:0]      r_now, n_now;
    logic [IDX_W-1:0] r_slot, n_slot;
    t_slot            r_best, n_best;
    logic [1:0]       r_res_status, n_res_status;
    logic [31:0]      r_res_id, n_res_id;
    logic [31:0]      r_res_rem, n_res_rem;
    logic             r_res_fired, n_res_fired;
    logic [1:0]       r_out_status, n_out_status;
    logic [31:0]      r_out_id, n_out_id;
    logic [31:0]      r_out_rem, n_out_rem;
    logic             r_out_fired, n_out_fired;

    // shared unit and memory hookup
    t_alu_op     alu_op;
    logic [63:0] alu_a;
    logic [63:0] alu_b;
    t_alu_res    alu_res;
    t_slot       rd_slot;
    logic        mem_we;
    t_slot       mem_wdata;
    logic        take;
    logic        slot_v;
    logic        due_later;

    tqm_store #(
        .DEPTH (MAX_TIMERS),
        .IDX_W (IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_slot),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx),
        .o_rdata (rd_slot)
    );

    tqm_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    // adder operand select by sequencer step
    always_comb begin
        alu_op = ALU_SUB;
        alu_a  = rd_slot.due;
        alu_b  = r_best.due;
        case (r_state)
            S_FIN: begin
                if (r_req_type == REQ_ADD || r_req_type == REQ_CHANGE) begin
                    alu_op = ALU_ADD;
                    alu_a  = r_now;
                    alu_b  = {32'd0, r_ivl};
                end else begin
                    alu_op = ALU_SUB;
                    alu_a  = r_best.due;
                    alu_b  = r_now;
                end
            end
            S_REARM: begin
                alu_op = ALU_ADD;
                alu_a  = r_best.due;
                alu_b  = {32'd0, r_best.interval};
            end
            default: begin
                alu_op = ALU_SUB;
                alu_a  = rd_slot.due;
                alu_b  = r_best.due;
            end
        endcase
    end

    // per-slot candidate test on the slot just read
    always_comb begin
        slot_v = r_valid[r_rd_idx];
        case (r_req_type)
            REQ_ADD:    take = !slot_v && !r_found;
            REQ_CANCEL: take = slot_v && (rd_slot.id == r_tid) && !r_found;
            REQ_CHANGE: take = slot_v && (rd_slot.id == r_tid) && !r_found;
            REQ_QUERY:  take = slot_v && (rd_slot.id == r_tid) && !r_found;
            REQ_TICK:   take = slot_v && (!r_found || alu_res.neg);
            default:    take = 1'b0;
        endcase
    end

    assign due_later = !alu_res.zero && !alu_res.neg;

    // sequencer next state and datapath
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_rd_vld     = (r_state == S_SCAN);
        n_rd_idx     = r_idx;
        n_found      = r_found;
        n_valid      = r_valid;
        n_next_id    = r_next_id;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_req_type   = r_req_type;
        n_tid        = r_tid;
        n_ivl        = r_ivl;
        n_per        = r_per;
        n_now        = r_now;
        n_slot       = r_slot;
        n_best       = r_best;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_res_rem    = r_res_rem;
        n_res_fired  = r_res_fired;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        n_out_rem    = r_out_rem;
        n_out_fired  = r_out_fired;
        mem_we       = 1'b0;
        mem_wdata    = r_best;

        // record the chosen slot as reads come back
        if (r_rd_vld && take) begin
            n_found = 1'b1;
            n_slot  = r_rd_idx;
            n_best  = rd_slot;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_req_type = i_s_axis_tuser;
                    n_tid      = i_s_axis_tdata[31:0];
                    n_ivl      = i_s_axis_tdata[63:32];
                    n_per      = i_s_axis_tdata[64];
                    n_now      = i_s_axis_tdata[128:65];
                    n_found    = 1'b0;
                    n_idx      = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_TAIL;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_TAIL: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                n_res_status = STS_OK;
                n_res_id     = 32'd0;
                n_res_rem    = 32'd0;
                n_res_fired  = 1'b0;
                n_state      = S_PUSH;
                case (r_req_type)
                    REQ_ADD: begin
                        if (r_found) begin
                            mem_we             = 1'b1;
                            mem_wdata.id       = r_next_id;
                            mem_wdata.due      = alu_res.sum;
                            mem_wdata.interval = r_ivl;
                            mem_wdata.periodic = r_per;
                            n_valid[r_slot]    = 1'b1;
                            n_res_id           = r_next_id;
                            n_next_id          = r_next_id + 32'd1;
                        end else begin
                            n_res_status = STS_FULL;
                        end
                    end
                    REQ_CANCEL: begin
                        if (r_found) begin
                            n_valid[r_slot] = 1'b0;
                        end else begin
                            n_res_status = STS_NOT_FOUND;
                        end
                    end
                    REQ_CHANGE: begin
                        if (r_found) begin
                            mem_we             = 1'b1;
                            mem_wdata.id       = r_best.id;
                            mem_wdata.due      = alu_res.sum;
                            mem_wdata.interval = r_ivl;
                            mem_wdata.periodic = r_per;
                        end else begin
                            n_res_status = STS_NOT_FOUND;
                        end
                    end
                    REQ_QUERY: begin
                        if (!r_found) begin
                            n_res_status = STS_NOT_FOUND;
                        end else if (due_later) begin
                            n_res_rem = alu_res.sum[31:0];
                        end
                    end
                    REQ_TICK: begin
                        if (!r_found || due_later) begin
                            n_res_status = STS_NONE_DUE;
                        end else begin
                            n_res_id    = r_best.id;
                            n_res_fired = 1'b1;
                            if (r_best.periodic) begin
                                n_state = S_REARM;
                            end else begin
                                n_valid[r_slot] = 1'b0;
                            end
                        end
                    end
                    default: begin
                        n_res_status = STS_OK;
                    end
                endcase
            end
            S_REARM: begin
                // periodic timer: next due is old due plus interval
                mem_we        = 1'b1;
                mem_wdata     = r_best;
                mem_wdata.due = alu_res.sum;
                n_state       = S_PUSH;
            end
            S_PUSH: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_id     = r_res_id;
                    n_out_rem    = r_res_rem;
                    n_out_fired  = r_res_fired;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_idx    <= '0;
            r_found     <= 1'b0;
            r_valid     <= '0;
            r_next_id   <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_rd_vld    <= n_rd_vld;
            r_rd_idx    <= n_rd_idx;
            r_found     <= n_found;
            r_valid     <= n_valid;
            r_next_id   <= n_next_id;
            r_out_valid <= n_out_valid;
        end
    end

    // request, candidate and response payload
    always_ff @(posedge i_clk) begin
        r_req_type   <= n_req_type;
        r_tid        <= n_tid;
        r_ivl        <= n_ivl;
        r_per        <= n_per;
        r_now        <= n_now;
        r_slot       <= n_slot;
        r_best       <= n_best;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_res_rem    <= n_res_rem;
        r_res_fired  <= n_res_fired;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
        r_out_rem    <= n_out_rem;
        r_out_fired  <= n_out_fired;
    end

    // stream ports
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_fired, r_out_rem, r_out_id};
    assign o_m_axis_tuser  = r_out_status;

    // checks
    `TQM_ASSERT_NOW(a_found_slot_live,
        (r_state == S_FIN) && r_found && (r_req_type != REQ_ADD),
        r_valid[r_slot])
    `TQM_ASSERT_NEXT(a_add_grows_table,
        (r_state == S_FIN) && r_found && (r_req_type == REQ_ADD),
        $countones(r_valid) == $past($countones(r_valid)) + 1)
    `TQM_ASSERT_NEXT(a_id_only_on_add,
        !((r_state == S_FIN) && r_found && (r_req_type == REQ_ADD)),
        r_next_id == $past(r_next_id))
    `TQM_ASSERT_NOW(a_read_follows_scan,
        r_rd_vld,
        $past(r_state) == S_SCAN)

endmodule

/* sim/timer_queue_manager_test.sv */
`timescale 1ns / 100ps

module timer_queue_manager_test;
    import tqm_pkg::*;

    localparam int N_SLOTS        = MAX_TIMERS_DEF;
    localparam int PLAN_ROWS      = 25;
    localparam int RAND_ITEMS     = 1850;
    localparam int CALM_ITEMS     = 150;
    localparam int HOLD_AT        = 600;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 2 * N_SLOTS + 8;

    // request codes the block leaves unused
    localparam logic [2:0] REQ_RSVD5 = 3'd5;
    localparam logic [2:0] REQ_RSVD6 = 3'd6;
    localparam logic [2:0] REQ_RSVD7 = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] id;
        logic [31:0] ivl;
        logic        per;
        logic [63:0] now;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] rid;
        logic [31:0] rem;
        logic        fired;
    } t_resp;

    // one line of the directed plan; reps repeats the request
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] id;
        logic [31:0] ivl;
        logic        per;
        logic [63:0] now;
        int          reps;
        bit          typed;
        t_resp       want;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 s_valid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_ready = 1'b0;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic [M_TUSER_W-1:0] o_m_axis_tuser;

    // timer table as the block should hold it
    t_slot       tbl [N_SLOTS];
    logic        tbl_valid [N_SLOTS];
    logic [31:0] id_counter;

    t_resp awaited_resp [$];
    t_row  plan [PLAN_ROWS];
    int    n_errors = 0;
    int    n_checked = 0;
    bit    calm = 1'b0;
    bit    hold_req = 1'b0;
    logic [63:0] now_t;

    timer_queue_manager DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        // req_id[31:0], interval[63:32], periodic[64], now_time[128:65]
        .i_s_axis_tdata  (s_tdata),
        // req_type[2:0]
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        // result_id[31:0], remaining[63:32], fired[64]
        .o_m_axis_tdata  (o_m_axis_tdata),
        // status[1:0]
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h (response %0d)", what, got, want,
                 n_checked);
        n_errors++;
    endtask

    // lowest valid slot holding the id, or -1
    function automatic int slot_of(input logic [31:0] id);
        int i;
        slot_of = -1;
        for (i = N_SLOTS - 1; i >= 0; i--)
            if (tbl_valid[i] && tbl[i].id == id) slot_of = i;
    endfunction

    // applies one request to the table and returns the response it earns
    function automatic t_resp serve_request(input t_req r);
        t_resp       rsp;
        int          s;
        int          i;
        logic [63:0] d;
        rsp = '0;
        s = -1;
        case (r.kind)
            REQ_ADD: begin
                for (i = N_SLOTS - 1; i >= 0; i--)
                    if (!tbl_valid[i]) s = i;
                if (s < 0) begin
                    rsp.status = STS_FULL;
                end else begin
                    tbl_valid[s] = 1'b1;
                    tbl[s].id = id_counter;
                    tbl[s].due = r.now + {32'b0, r.ivl};
                    tbl[s].interval = r.ivl;
                    tbl[s].periodic = r.per;
                    rsp.rid = id_counter;
                    id_counter = id_counter + 1;
                end
            end
            REQ_CANCEL: begin
                s = slot_of(r.id);
                if (s < 0) rsp.status = STS_NOT_FOUND;
                else tbl_valid[s] = 1'b0;
            end
            REQ_CHANGE: begin
                s = slot_of(r.id);
                if (s < 0) begin
                    rsp.status = STS_NOT_FOUND;
                end else begin
                    tbl[s].interval = r.ivl;
                    tbl[s].periodic = r.per;
                    tbl[s].due = r.now + {32'b0, r.ivl};
                end
            end
            REQ_QUERY: begin
                s = slot_of(r.id);
                if (s < 0) begin
                    rsp.status = STS_NOT_FOUND;
                end else begin
                    d = tbl[s].due - r.now;
                    if (d != 0 && !d[63]) rsp.rem = d[31:0];
                end
            end
            REQ_TICK: begin
                // earliest due by signed difference, lowest slot on ties
                for (i = 0; i < N_SLOTS; i++) begin
                    if (tbl_valid[i]) begin
                        d = tbl[i].due - ((s < 0) ? tbl[i].due : tbl[s].due);
                        if (s < 0 || d[63]) s = i;
                    end
                end
                if (s < 0) begin
                    rsp.status = STS_NONE_DUE;
                end else begin
                    d = tbl[s].due - r.now;
                    if (d != 0 && !d[63]) begin
                        rsp.status = STS_NONE_DUE;
                    end else begin
                        rsp.rid = tbl[s].id;
                        rsp.fired = 1'b1;
                        if (tbl[s].periodic) tbl[s].due = tbl[s].due + {32'b0, tbl[s].interval};
                        else tbl_valid[s] = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    // offers one request and waits for its transaction
    task automatic offer(input t_req r, input bit typed, input t_resp want);
        t_resp rsp;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_tdata <= {7'b0, r.now, r.per, r.ivl, r.id};
        s_tuser <= r.kind;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        rsp = serve_request(r);
        awaited_resp.push_back(typed ? want : rsp);
    endtask

    // id for cancel, change or query: mostly live, some stale or arbitrary
    function automatic logic [31:0] pick_id();
        logic [31:0] live [$];
        int          i;
        for (i = 0; i < N_SLOTS; i++)
            if (tbl_valid[i]) live.push_back(tbl[i].id);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return id_counter - $urandom_range(1, 30);
            default: return (live.size() != 0) ? live[$urandom_range(0, live.size() - 1)]
                                               : $urandom;
        endcase
    endfunction

    // response side: check each transaction, stall in bursts
    always @(posedge i_clk) begin : response_side
        t_resp got;
        t_resp want;
        int    stall_left;
        bit    hold_done;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            got = {o_m_axis_tuser, o_m_axis_tdata[31:0], o_m_axis_tdata[63:32],
                   o_m_axis_tdata[64]};
            if (awaited_resp.size() == 0) begin
                report_mismatch("unexpected response", 64'(got), 64'h0);
            end else begin
                want = awaited_resp.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.rid !== want.rid)
                    report_mismatch("result_id", 64'(got.rid), 64'(want.rid));
                if (got.rem !== want.rem)
                    report_mismatch("remaining", 64'(got.rem), 64'(want.rem));
                if (got.fired !== want.fired)
                    report_mismatch("fired", 64'(got.fired), 64'(want.fired));
            end
            n_checked++;
        end
        // one long hold-off so the block fills up and stalls its input
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin : watchdog
        int quiet_cycles;
        if (!i_rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        t_req r;
        int   n;
        int   k;
        int   w_add;
        int   pick;
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
        id_counter = '0;
        now_t = '0;

        // kind, id, interval, periodic, time, reps, typed, expected response
        plan = '{
            // tick, query, cancel, change on an empty table
            '{REQ_TICK,   32'h0, 32'h0, 1'b0, 64'h0, 1, 1'b1, '{STS_NONE_DUE, 32'h0, 32'h0, 1'b0}},
            '{REQ_QUERY,  32'h0, 32'h0, 1'b0, 64'h0, 1, 1'b1, '{STS_NOT_FOUND, 32'h0, 32'h0, 1'b0}},
            '{REQ_CANCEL, 32'hFFFF_FFFF, 32'h0, 1'b0, 64'h0, 1, 1'b1,
              '{STS_NOT_FOUND, 32'h0, 32'h0, 1'b0}},
            '{REQ_CHANGE, 32'h5, 32'h7, 1'b1, 64'h0, 1, 1'b1, '{STS_NOT_FOUND, 32'h0, 32'h0, 1'b0}},
            // zero interval, then largest interval with the time wrapping
            '{REQ_ADD,    32'h0, 32'h0, 1'b0, 64'h0, 1, 1'b1, '{STS_OK, 32'h0, 32'h0, 1'b0}},
            '{REQ_ADD,    32'h0, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1'b1,
              '{STS_OK, 32'h1, 32'h0, 1'b0}},
            '{REQ_QUERY,  32'h0, 32'h0, 1'b0, 64'h0, 1, 1'b1, '{STS_OK, 32'h0, 32'h0, 1'b0}},
            '{REQ_QUERY,  32'h1, 32'h0, 1'b0, 64'h0, 1, 1'b0, '0},
            '{REQ_TICK,   32'h0, 32'h0, 1'b0, 64'h0, 1, 1'b0, '0},
            '{REQ_TICK,   32'h0, 32'h0, 1'b0, 64'h0, 1, 1'b0, '0},
            '{REQ_TICK,   32'h0, 32'h0, 1'b0, 64'hFFFF_FFFE, 1, 1'b0, '0},
            // time at the sign boundary
            '{REQ_CHANGE, 32'h1, 32'h5, 1'b0, 64'h8000_0000_0000_0000, 1, 1'b1,
              '{STS_OK, 32'h0, 32'h0, 1'b0}},
            '{REQ_QUERY,  32'h1, 32'h0, 1'b0, 64'h8000_0000_0000_0000, 1, 1'b1,
              '{STS_OK, 32'h0, 32'h5, 1'b0}},
            '{REQ_QUERY,  32'h1, 32'h0, 1'b0, 64'h8000_0000_0000_0010, 1, 1'b1,
              '{STS_OK, 32'h0, 32'h0, 1'b0}},
            // unused codes with every field at ones
            '{REQ_RSVD5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1'b1,
              '{STS_OK, 32'h0, 32'h0, 1'b0}},
            '{REQ_RSVD6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1'b1,
              '{STS_OK, 32'h0, 32'h0, 1'b0}},
            '{REQ_RSVD7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1'b1,
              '{STS_OK, 32'h0, 32'h0, 1'b0}},
            // fill the table with equal due times, then one add too many
            '{REQ_ADD,    32'h0, 32'd100, 1'b0, 64'h100, 15, 1'b0, '0},
            '{REQ_ADD,    32'h0, 32'd100, 1'b0, 64'h100, 1, 1'b1, '{STS_FULL, 32'h0, 32'h0, 1'b0}},
            '{REQ_QUERY,  32'd16, 32'h0, 1'b0, 64'h100, 1, 1'b1, '{STS_OK, 32'h0, 32'd100, 1'b0}},
            // tie on due time goes to the lowest slot
            '{REQ_TICK,   32'h0, 32'h0, 1'b0, 64'h1000, 1, 1'b0, '0},
            '{REQ_CANCEL, 32'd3, 32'h0, 1'b0, 64'h1000, 1, 1'b1, '{STS_OK, 32'h0, 32'h0, 1'b0}},
            '{REQ_ADD,    32'h0, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF_0000_0000, 1, 1'b0, '0},
            '{REQ_CANCEL, 32'h1, 32'h0, 1'b0, 64'h1000, 1, 1'b1, '{STS_OK, 32'h0, 32'h0, 1'b0}},
            '{REQ_TICK,   32'h0, 32'h0, 1'b0, 64'h1000, 1, 1'b0, '0}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed plan
        for (n = 0; n < PLAN_ROWS; n++) begin
            for (k = 0; k < plan[n].reps; k++) begin
                r = '{plan[n].kind, plan[n].id, plan[n].ivl, plan[n].per, plan[n].now};
                offer(r, plan[n].typed, plan[n].want);
            end
        end

        // random traffic in phases of changing add pressure
        now_t = 64'h2000;
        w_add = 25;
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n % 150 == 0) begin
                case ($urandom_range(0, 2))
                    0: w_add = 10;
                    1: w_add = 25;
                    default: w_add = 45;
                endcase
            end
            if (n == HOLD_AT) hold_req <= 1'b1;
            if (n == RAND_ITEMS - CALM_ITEMS) calm <= 1'b1;

            // time mostly creeps forward, now and then jumps or wraps
            case ($urandom_range(0, 49))
                0: now_t = {$urandom, $urandom};
                1: now_t = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 300);
                default: now_t = now_t + $urandom_range(0, 30);
            endcase
            r.now = ($urandom_range(0, 49) == 0) ? {$urandom, $urandom} : now_t;
            case ($urandom_range(0, 9))
                0: r.ivl = $urandom;
                1: r.ivl = $urandom_range(0, 3);
                default: r.ivl = $urandom_range(0, 150);
            endcase
            r.per = $urandom_range(0, 1);
            r.id = $urandom;

            pick = $urandom_range(0, 99);
            if (pick < w_add) begin
                r.kind = REQ_ADD;
            end else if (pick < w_add + 10) begin
                r.kind = REQ_CANCEL;
                r.id = pick_id();
            end else if (pick < w_add + 20) begin
                r.kind = REQ_CHANGE;
                r.id = pick_id();
            end else if (pick < w_add + 38) begin
                r.kind = REQ_QUERY;
                r.id = pick_id();
            end else if (pick < w_add + 40) begin
                r.kind = REQ_RSVD5 + 3'($urandom_range(0, 2));
            end else begin
                r.kind = REQ_TICK;
            end
            offer(r, 1'b0, '0);
        end
        s_valid <= 1'b0;

        // drain
        while (awaited_resp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
